// ----- rtl/sla_pkg.sv -----
`default_nettype none
package sla_pkg;

  // Characters kept in one line; the store has one spare slot beyond this.
  localparam int LINE_CAPACITY = 63;
  localparam int STORE_DEPTH   = LINE_CAPACITY + 1;
  localparam int IDX_W         = $clog2(STORE_DEPTH);
  localparam int BYTE_W        = 8;
  localparam int LEN_W         = ((IDX_W > BYTE_W) ? IDX_W : BYTE_W) + 1;

  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Request from the assembler to start reading out a finished line.
  typedef struct packed {
    logic start;
    idx_t count;
    logic binary;
  } drain_req_t;

endpackage
`default_nettype wire

// ----- rtl/serial_line_assembler.sv -----
// Serial line assembler.
// The input channel (in_valid, in_stall, in_rx_byte) takes one received byte
// per word. Outside a line read-out every byte is taken in the cycle in which it is offered, so the
// block keeps pace with any serial source.
// When a byte finishes a line (a newline or return in text mode, the last
// payload byte of a binary frame), the line is read out of the line store on
// the output channel (out_valid, out_stall, out_line_byte, out_is_binary,
// out_last), one word per byte, with out_last on the final one.
// After the finishing byte is taken, the read-out passes through a read
// state, in which the store's synchronous read port is read, and then a
// show state, in which the word is presented; each further word is read
// and presented the same way after its predecessor is taken. in_stall is
// held high for that whole read-out.
// When the receiver stalls, the current output word holds unchanged and the
// read-out simply waits.
// Reset (synchronous, rst_n low) returns the assembler to text mode at the
// start of a line and abandons any read-out; the store itself is not cleared,
// as only bytes written for the current line are ever read.
`default_nettype none
module serial_line_assembler (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sla_pkg::byte_t in_rx_byte,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sla_pkg::byte_t      out_line_byte,
  output logic               out_is_binary,
  output logic               out_last
);
  import sla_pkg::*;

  logic       accept;
  logic       busy;
  logic       wr_en;
  idx_t       wr_addr;
  byte_t      wr_data;
  logic       rd_en;
  idx_t       rd_addr;
  byte_t      rd_data;
  drain_req_t req;

  // Input is held off for as long as a line is being read out.
  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  // Parses each byte, writes kept bytes to the store and signals line end.
  sla_assembler u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .req     (req)
  );

  // The line store: one write port for assembly, one registered read port.
  sla_line_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Walks the finished line through the read port onto the output channel.
  // The read of the first byte follows the write of the last one, so no
  // forwarding is needed.
  sla_drain u_drain (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .busy          (busy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_byte (out_line_byte),
    .out_is_binary (out_is_binary),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ----- rtl/sla_line_ram.sv -----
`default_nettype none
module sla_line_ram (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire sla_pkg::idx_t  wr_addr,
  input  wire sla_pkg::byte_t wr_data,
  input  wire logic          rd_en,
  input  wire sla_pkg::idx_t  rd_addr,
  output sla_pkg::byte_t      rd_data
);
  import sla_pkg::*;

  byte_t mem [STORE_DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/sla_assembler.sv -----
`default_nettype none
module sla_assembler (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire sla_pkg::byte_t     rx_byte,
  output logic                   wr_en,
  output sla_pkg::idx_t           wr_addr,
  output sla_pkg::byte_t          wr_data,
  output sla_pkg::drain_req_t     req
);
  import sla_pkg::*;

  typedef enum logic [2:0] {
    PH_TEXT  = 3'b001,
    PH_COUNT = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  phase_t phase_r, phase_nxt;
  idx_t   widx_r, widx_nxt;
  idx_t   rem_r, rem_nxt;

  logic [LEN_W-1:0] lim;
  logic [LEN_W-1:0] bp1;
  logic [LEN_W-1:0] len;
  idx_t             idx_inc;
  idx_t             rem_dec;

  always_comb begin
    lim     = (rem_r == '0) ? '0 : (LEN_W'(rem_r) - LEN_W'(1));
    bp1     = LEN_W'(rx_byte) + LEN_W'(1);
    len     = (lim > bp1) ? bp1 : lim;
    if (len == '0) begin
      len = LEN_W'(1);
    end
    idx_inc = widx_r + idx_t'(1);
    rem_dec = (rem_r == '0) ? '0 : (rem_r - idx_t'(1));
  end

  always_comb begin
    phase_nxt  = phase_r;
    widx_nxt   = widx_r;
    rem_nxt    = rem_r;
    wr_en      = 1'b0;
    wr_addr    = widx_r;
    wr_data    = rx_byte;
    req.start  = 1'b0;
    req.count  = widx_r;
    req.binary = 1'b0;
    if (accept) begin
      case (phase_r)
        PH_COUNT: begin
          wr_en     = 1'b1;
          widx_nxt  = idx_inc;
          rem_nxt   = idx_t'(len);
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          wr_en = 1'b1;
          if (rem_dec == '0) begin
            req.start  = 1'b1;
            req.count  = idx_inc;
            req.binary = 1'b1;
            widx_nxt   = '0;
            rem_nxt    = idx_t'(LINE_CAPACITY);
            phase_nxt  = PH_TEXT;
          end else begin
            widx_nxt = idx_inc;
            rem_nxt  = rem_dec;
          end
        end
        default: begin
          if (widx_r == '0 && rx_byte == BYTE_ZERO) begin
            // A zero byte at line start opens a binary frame.
            wr_en     = 1'b1;
            widx_nxt  = idx_t'(1);
            rem_nxt   = idx_t'(LINE_CAPACITY - 1);
            phase_nxt = PH_COUNT;
          end else if (widx_r == '0 && rx_byte < CTRL_LIMIT) begin
            phase_nxt = PH_TEXT;
          end else if (rx_byte inside {CHAR_LF, CHAR_CR}) begin
            req.start = 1'b1;
            widx_nxt  = '0;
            rem_nxt   = idx_t'(LINE_CAPACITY);
            phase_nxt = PH_TEXT;
          end else begin
            // Once the line is full, characters land in the spare slot.
            wr_en = 1'b1;
            if (rem_r != '0) begin
              widx_nxt = idx_inc;
              rem_nxt  = rem_dec;
            end
            phase_nxt = PH_TEXT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      widx_r  <= '0;
      rem_r   <= idx_t'(LINE_CAPACITY);
    end else begin
      phase_r <= phase_nxt;
      widx_r  <= widx_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sla_drain.sv -----
`default_nettype none
module sla_drain (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sla_pkg::drain_req_t req,
  output logic                   busy,
  output logic                   rd_en,
  output sla_pkg::idx_t           rd_addr,
  input  wire sla_pkg::byte_t     rd_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sla_pkg::byte_t          out_line_byte,
  output logic                   out_is_binary,
  output logic                   out_last
);
  import sla_pkg::*;

  typedef enum logic [2:0] {
    DR_IDLE = 3'b001,
    DR_READ = 3'b010,
    DR_SHOW = 3'b100
  } dr_state_t;

  dr_state_t state_r, state_nxt;
  idx_t      ptr_r, ptr_nxt;
  idx_t      cnt_r, cnt_nxt;
  logic      bin_r, bin_nxt;
  logic      at_last;

  assign at_last = (ptr_r == (cnt_r - idx_t'(1)));

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    bin_nxt   = bin_r;
    case (state_r)
      DR_IDLE: begin
        if (req.start) begin
          ptr_nxt   = '0;
          cnt_nxt   = req.count;
          bin_nxt   = req.binary;
          state_nxt = DR_READ;
        end
      end
      DR_READ: begin
        state_nxt = DR_SHOW;
      end
      DR_SHOW: begin
        if (!out_stall) begin
          if (at_last) begin
            state_nxt = DR_IDLE;
          end else begin
            ptr_nxt   = ptr_r + idx_t'(1);
            state_nxt = DR_READ;
          end
        end
      end
      default: begin
        state_nxt = DR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DR_IDLE;
      ptr_r   <= '0;
      cnt_r   <= '0;
      bin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      cnt_r   <= cnt_nxt;
      bin_r   <= bin_nxt;
    end
  end

  assign busy          = (state_r != DR_IDLE);
  assign rd_en         = (state_r == DR_READ);
  assign rd_addr       = ptr_r;
  assign out_valid     = (state_r == DR_SHOW);
  assign out_line_byte = rd_data;
  assign out_is_binary = bin_r;
  assign out_last      = at_last;

endmodule
`default_nettype wire

// ----- rtl/sla_checker.sv -----
`default_nettype none
module sla_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire sla_pkg::byte_t out_line_byte,
  input wire logic          out_is_binary,
  input wire logic          out_last
);
  import sla_pkg::*;

  // A stalled output word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_byte)
      && $stable(out_is_binary) && $stable(out_last))
    else $error("stalled output word changed");

  // No byte is taken while a line is being read out.
  a_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during read-out");

  // After the final word the read-out ends.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid && !in_stall)
    else $error("read-out did not end after last word");

  // The next word of a run follows after a read of the store, same frame kind.
  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> in_stall && !out_valid
      ##1 out_valid && (out_is_binary == $past(out_is_binary, 2)))
    else $error("line run broken");

endmodule

bind serial_line_assembler sla_checker u_sla_checker (.*);
`default_nettype wire

// ----- verif/tb_serial_line_assembler.sv -----
`default_nettype none
module tb_serial_line_assembler;
  timeunit 1ns;
  timeprecision 1ps;

  import sla_pkg::*;

  // Cycles without any accepted word, on either channel, before the run is
  // declared hung. A full line read-out against a heavily stalling receiver
  // needs only a small fraction of this.
  localparam int QUIET_LIMIT = 2000;

  // Cycles allowed after the last expected word before the final verdict.
  localparam int TAIL_CYCLES = 20;

  // Assembly phase of the line being built.
  typedef enum logic [1:0] {
    PH_TEXT,
    PH_COUNT,
    PH_DATA
  } line_phase_t;

  // One word of a finished line as the result channel should present it.
  typedef struct packed {
    byte_t data;
    logic  binary;
    logic  last;
  } line_word_t;

  // Predicts the lines that the assembler gives out and checks each read-out
  // word against the oldest one still owed.
  class line_scoreboard;
    byte_t        store [STORE_DEPTH];
    int           wr_idx;
    line_phase_t  ph;
    int           left;
    line_word_t   expected_words [$];
    int           bytes_taken;
    int           fault_count;

    function new();
      restart();
      bytes_taken = 0;
      fault_count = 0;
    endfunction

    function void restart();
      wr_idx = 0;
      ph = PH_TEXT;
      left = LINE_CAPACITY;
    endfunction

    function void finish_line(logic binary);
      for (int k = 0; k < wr_idx; k++) begin
        expected_words.push_back(line_word_t'{store[k], binary, (k + 1 == wr_idx)});
      end
      restart();
    endfunction

    // Updates the line state for one accepted byte; bytes that are simply
    // skipped at the start of a text line do not count as taken.
    function void note_byte(byte_t b);
      int len;
      if (wr_idx > LINE_CAPACITY) restart();
      case (ph)
        PH_COUNT: begin
          len = (left != 0) ? left - 1 : 0;
          store[wr_idx] = b;
          wr_idx++;
          if (len > int'(b) + 1) len = int'(b) + 1;
          if (len == 0) len = 1;
          left = len;
          ph = PH_DATA;
        end
        PH_DATA: begin
          store[wr_idx] = b;
          wr_idx++;
          if (left != 0) left--;
          if (left == 0 || wr_idx > LINE_CAPACITY) finish_line(1'b1);
        end
        default: begin
          if (wr_idx == 0) begin
            if (b == BYTE_ZERO) begin
              store[0] = BYTE_ZERO;
              wr_idx = 1;
              left = LINE_CAPACITY - 1;
              ph = PH_COUNT;
              bytes_taken++;
              return;
            end
            if (b < CTRL_LIMIT) return;
          end
          if (b == CHAR_LF || b == CHAR_CR) begin
            finish_line(1'b0);
          end else begin
            // Once the line is full the spare slot is overwritten and the
            // index stays put, so the extra characters never come out.
            store[wr_idx] = b;
            if (left != 0) begin
              wr_idx++;
              left--;
            end
            ph = PH_TEXT;
          end
        end
      endcase
      bytes_taken++;
    endfunction

    function void check_word(byte_t data, logic binary, logic last);
      line_word_t want;
      if (expected_words.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected word: byte %02h binary %b last %b",
                   $realtime, data, binary, last);
        return;
      end
      want = expected_words.pop_front();
      if (data !== want.data || binary !== want.binary || last !== want.last) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: mismatch: expected byte %02h binary %b last %b, got byte %02h binary %b last %b",
                   $realtime, want.data, want.binary, want.last, data, binary, last);
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t in_rx_byte = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_line_byte;
  logic  out_is_binary;
  logic  out_last;

  line_scoreboard sb = new();

  // Percentage of cycles in which each side holds back.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  serial_line_assembler uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_line_byte (out_line_byte),
    .out_is_binary (out_is_binary),
    .out_last      (out_last)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver decides at each falling edge whether to stall the next
  // rising edge. It never stalls during reset.
  always @(negedge clk) begin
    out_stall = rst_n && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Every word that crosses the result channel is checked at the rising
  // edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_line_byte, out_is_binary, out_last);
  end

  // Watchdog: a run in which nothing moves on either channel for too long
  // is taken to have hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one byte, starting and ending at a falling edge. The sender may
  // idle first; once valid is raised the byte is held until it is taken.
  task automatic send_byte(byte_t value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_rx_byte = value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(value);
    @(negedge clk);
  endtask

  // Ordinary text characters most of the time, but any byte other than a
  // terminator now and then, so that zero and control bytes inside a line
  // are exercised as well.
  function automatic byte_t text_char();
    int sel;
    byte_t c;
    sel = $urandom_range(0, 9);
    if (sel < 7) return byte_t'($urandom_range(8'h20, 8'h7E));
    if (sel < 9) return byte_t'($urandom_range(8'h80, 8'hFF));
    do c = byte_t'($urandom_range(0, 255)); while (c == CHAR_LF || c == CHAR_CR);
    return c;
  endfunction

  // A text line of n_chars characters, sometimes preceded by control bytes
  // which the assembler should skip, ended by a newline or a return.
  task automatic send_text_line(int n_chars);
    int lead;
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (lead) send_byte(byte_t'($urandom_range(1, 8'h1F)));
    send_byte(byte_t'($urandom_range(CTRL_LIMIT, 8'hFF)));
    repeat (n_chars - 1) send_byte(text_char());
    send_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
  endtask

  // A binary frame: zero, the count, then the payload, whose length is
  // the count plus one but never more than the line allows.
  task automatic send_binary_frame(int count);
    int n_payload;
    n_payload = (count + 1 < LINE_CAPACITY - 2) ? count + 1 : LINE_CAPACITY - 2;
    send_byte(BYTE_ZERO);
    send_byte(byte_t'(count));
    repeat (n_payload) send_byte(byte_t'($urandom_range(0, 255)));
  endtask

  // Stops sending until every line owed has been read out.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed lines and frames with random content; the rest is
  // loose bytes that break sequences up or leave partial lines behind.
  task automatic run_random(int target);
    int pick;
    int sel;
    while (sb.bytes_taken < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_text_line($urandom_range(1, 12));
      end else if (pick < 52) begin
        send_text_line($urandom_range(13, 40));
      end else if (pick < 55) begin
        send_text_line($urandom_range(60, 70));
      end else if (pick < 88) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) send_binary_frame($urandom_range(0, 8));
        else if (sel < 9) send_binary_frame($urandom_range(9, 64));
        else send_binary_frame($urandom_range(200, 255));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    byte_t directed [$];

    // Hold reset, releasing it at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words, all sent without idling on either side:
    //  - control bytes skipped at line start, then a line holding a zero byte,
    //    a control byte, the top byte and a space, ended by a newline;
    //  - empty lines ended by a newline and by a return;
    //  - a one-character line ended by a return;
    //  - a binary frame with count zero, hence a single payload byte;
    //  - a binary frame whose payload holds a newline, a return and a zero;
    //  - a short line to close the directed part.
    directed = '{8'h01, 8'h1F, 8'h48, BYTE_ZERO, 8'h01, 8'hFF, CTRL_LIMIT, CHAR_LF,
                 CHAR_LF, CHAR_CR,
                 8'h80, CHAR_CR,
                 BYTE_ZERO, 8'h00, 8'hA5,
                 BYTE_ZERO, 8'h02, CHAR_LF, CHAR_CR, BYTE_ZERO,
                 8'h7F, CHAR_LF};
    foreach (directed[i]) send_byte(directed[i]);

    // First random stretch: the sender idles seldom, the receiver often.
    // An overflowing text line and a frame with a saturating count are sent
    // up front, then the sender waits for the read-out to finish.
    send_idle_pct = 13;
    recv_idle_pct = 57;
    send_text_line(70);
    send_binary_frame(255);
    wait_drained();
    run_random(170);
    wait_drained();

    // Second stretch: the roles swap.
    send_idle_pct = 57;
    recv_idle_pct = 13;
    run_random(270);
    wait_drained();

    // Last stretch: neither side holds back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(350);

    // Let the final read-out complete, then watch a while for stray words.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.fault_count == 0 && sb.expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
